@@ design/rsf_pkg.sv @@
// rsf_pkg: shared types, register codes and gap constants for the rtu silence framer
// no dependencies; imported by every rsf module and by rtu_silence_framer
`default_nettype none

package rsf_pkg;

  // sizes fixed by the field definitions
  localparam int unsigned CFG_DATA_W      = 26;
  localparam int unsigned CFG_INDEX_W     = 3;
  localparam int unsigned GAP_W           = 26;
  localparam int unsigned BAUD_W          = 22;
  localparam int unsigned DEN_W           = BAUD_W + 1;
  localparam int unsigned NUM_W           = 28;
  localparam int unsigned BITS_W          = 5;
  localparam int unsigned MAX_FRAME_BYTES = 256;

  // gap arithmetic: gap = ceil(k * bits * 1e6 / (2 * baud)), k = 7 for 3.5, 3 for 1.5
  localparam int unsigned BAUD_FIXED_ABOVE = 19200;
  localparam int unsigned FRAME_FACTOR     = 7000000;
  localparam int unsigned CHAR_FACTOR      = 3000000;
  localparam int unsigned FIXED_FRAME_GAP  = 1750;
  localparam int unsigned FIXED_CHAR_GAP   = 750;

  // stop bit codes
  localparam logic [1:0] STOP_TWO      = 2'd2;
  localparam logic [1:0] STOP_ONE_HALF = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BAUD_RATE          = 3'd0,
    REG_DATA_BITS          = 3'd1,
    REG_PARITY_ENABLE      = 3'd2,
    REG_STOP_CODE          = 3'd3,
    REG_FRAME_GAP_OVERRIDE = 3'd4
  } rsf_reg_t;

  typedef struct packed {
    logic [BAUD_W-1:0] baud_rate;
    logic [3:0]        data_bits;
    logic              parity_enable;
    logic [1:0]        stop_code;
    logic [GAP_W-1:0]  frame_gap_override;
  } rsf_cfg_t;

  typedef struct packed {
    logic [GAP_W-1:0] frame_gap;
    logic [GAP_W-1:0] char_gap;
  } rsf_gaps_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } rsf_in_t;

  typedef struct packed {
    logic       frame_done;
    logic       gap_dropped;
    logic       overflow_dropped;
    logic [8:0] closed_length;
    logic       byte_valid;
    logic [7:0] byte_out;
    logic [7:0] byte_index;
  } rsf_out_t;

endpackage

`default_nettype wire

@@ design/rsf_gap_calc.sv @@
// rsf_gap_calc: works out the frame and character gaps from the line settings
// one shared restoring divider, one quotient bit per cycle; uses rsf_pkg
`default_nettype none

module rsf_gap_calc (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rsf_pkg::rsf_cfg_t cfg,
  output logic                   busy,
  output rsf_pkg::rsf_gaps_t     gaps
);
  import rsf_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV
  } state_t;

  state_t             state;
  logic               phase;     // 0 character gap, 1 frame gap
  logic [STEP_W-1:0]  step;
  logic [DEN_W:0]     rem;
  logic [NUM_W-1:0]   quo;

  logic [BITS_W-1:0]  char_bits;
  logic [DEN_W-1:0]   den;
  logic               fixed_gaps;
  logic [NUM_W-1:0]   factor;
  logic [NUM_W-1:0]   dividend;
  logic [DEN_W:0]     rem_sh;
  logic               fits;
  logic [DEN_W:0]     rem_next;
  logic [NUM_W-1:0]   quo_next;

  always_comb begin
    char_bits = BITS_W'(1) + BITS_W'(cfg.data_bits) + BITS_W'(cfg.parity_enable)
              + ((cfg.stop_code == STOP_TWO || cfg.stop_code == STOP_ONE_HALF) ?
                 BITS_W'(2) : BITS_W'(1));
    den        = {cfg.baud_rate, 1'b0};
    fixed_gaps = (cfg.baud_rate == '0) || (cfg.baud_rate > BAUD_W'(BAUD_FIXED_ABOVE));
    factor     = phase ? NUM_W'(FRAME_FACTOR) : NUM_W'(CHAR_FACTOR);
    // adding den - 1 turns the floor quotient into a ceiling
    dividend   = NUM_W'(NUM_W'(char_bits) * factor) + NUM_W'(den) - NUM_W'(1);

    rem_sh   = {rem[DEN_W-1:0], quo[NUM_W-1]};
    fits     = rem_sh >= {1'b0, den};
    rem_next = fits ? (rem_sh - {1'b0, den}) : rem_sh;
    quo_next = {quo[NUM_W-2:0], fits};
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      step  <= '0;
    end else if (start) begin
      state <= S_LOAD;
      phase <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_LOAD: begin
          quo   <= dividend;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          quo  <= quo_next;
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(NUM_W - 1)) begin
            if (!phase) begin
              gaps.char_gap <= fixed_gaps ? GAP_W'(FIXED_CHAR_GAP) : quo_next[GAP_W-1:0];
              phase         <= 1'b1;
              state         <= S_LOAD;
            end else begin
              if (cfg.frame_gap_override != '0) begin
                gaps.frame_gap <= cfg.frame_gap_override;
              end else if (fixed_gaps) begin
                gaps.frame_gap <= GAP_W'(FIXED_FRAME_GAP);
              end else begin
                gaps.frame_gap <= quo_next[GAP_W-1:0];
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/rsf_frame_core.sv @@
// rsf_frame_core: input register, per-word framing decision and result register
// holds the open byte count and the silence counter; uses rsf_pkg
`default_nettype none

module rsf_frame_core #(
  parameter int unsigned MAX_FRAME_BYTES = rsf_pkg::MAX_FRAME_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hold,
  input  wire logic               clr,
  input  wire rsf_pkg::rsf_gaps_t gaps,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rsf_pkg::rsf_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rsf_pkg::rsf_out_t       out_data
);
  import rsf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic             ir_valid;
  rsf_in_t          ir;
  logic [CNT_W-1:0] open_count;
  logic [GAP_W-1:0] silence_ticks;

  logic             move;
  logic [GAP_W-1:0] sil_inc;
  logic             frame_gap_hit;
  logic             char_gap_hit;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W:0]   cnt_plus;
  logic [CNT_W-1:0] open_count_next;
  logic [GAP_W-1:0] silence_ticks_next;
  rsf_out_t         res_next;

  assign move     = ir_valid && !hold && (!out_valid || out_ready);
  assign in_ready = !hold && (!ir_valid || move);

  always_comb begin
    sil_inc       = (silence_ticks == '1) ? silence_ticks : silence_ticks + GAP_W'(1);
    frame_gap_hit = 1'b0;
    char_gap_hit  = 1'b0;
    cnt_base      = open_count;
    cnt_plus      = '0;
    res_next      = '0;

    if (ir.mode) begin
      silence_ticks_next = sil_inc;
      open_count_next    = open_count;
      if (open_count != '0 && sil_inc >= gaps.frame_gap) begin
        res_next.frame_done    = 1'b1;
        res_next.closed_length = 9'(open_count);
        open_count_next        = '0;
      end
    end else begin
      silence_ticks_next = '0;
      if (open_count != '0) begin
        frame_gap_hit = silence_ticks >= gaps.frame_gap;
        char_gap_hit  = !frame_gap_hit && (silence_ticks > gaps.char_gap);
      end
      res_next.frame_done  = frame_gap_hit;
      res_next.gap_dropped = char_gap_hit;
      if (frame_gap_hit || char_gap_hit) begin
        res_next.closed_length = 9'(open_count);
        cnt_base               = '0;
      end
      // the byte reopens a frame at index 0 when it closed the previous one
      cnt_plus = {1'b0, cnt_base} + (CNT_W+1)'(1);
      if (cnt_plus > (CNT_W+1)'(MAX_FRAME_BYTES)) begin
        res_next.overflow_dropped = 1'b1;
        res_next.closed_length    = 9'(cnt_plus);
        open_count_next           = '0;
      end else begin
        res_next.byte_valid = 1'b1;
        res_next.byte_out   = ir.rx_byte;
        res_next.byte_index = 8'(cnt_base);
        open_count_next     = cnt_plus[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid      <= 1'b0;
      out_valid     <= 1'b0;
      open_count    <= '0;
      silence_ticks <= '0;
    end else begin
      if (in_valid && in_ready) begin
        ir_valid <= 1'b1;
      end else if (move) begin
        ir_valid <= 1'b0;
      end
      if (clr) begin
        open_count    <= '0;
        silence_ticks <= '0;
      end else if (move) begin
        open_count    <= open_count_next;
        silence_ticks <= silence_ticks_next;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir <= in_data;
    end
    if (move) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ design/rtu_silence_framer.sv @@
// rtu_silence_framer: top level of the serial line silence framer
// holds the line settings; instantiates rsf_gap_calc and rsf_frame_core; uses rsf_pkg
`default_nettype none

// usage
//   input channel (in_valid, in_ready, in_data): each word is either a received
//   byte (mode 0) or one elapsed microsecond (mode 1)
//   output channel (out_valid, out_ready, out_data): exactly one result word per
//   input word, in order: frame completed, fragment dropped on a character gap,
//   frame dropped on overflow, and the byte passed through with its index
//   words pass the input register, then the result register; throughput one word
//   per cycle unless held or stalled, set by the single framing stage between them
//   a stalled receiver holds the result register; the input register still takes
//   one more word, after which in_ready falls until the result is taken
//   configuration: cfg_we writes cfg_data to register cfg_index at once; a write
//   to a known register clears the open frame and the silence count and starts a
//   gap recalculation in the shared divider (two 28 step divisions plus a load
//   each), during which in_ready stays low
//   reset: settings return to 9600 baud, 8 data bits, no parity, one stop bit and
//   no override; the gaps for them are worked out in the same pass, so in_ready
//   rises when that pass ends, after rst falls

module rtu_silence_framer #(
  parameter int unsigned MAX_FRAME_BYTES = rsf_pkg::MAX_FRAME_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rsf_pkg::rsf_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rsf_pkg::rsf_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [rsf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rsf_pkg::*;

  rsf_cfg_t  cfg;
  logic      recalc;      // gap recalculation pending, raised by reset or a write to a known register
  logic      cfg_hit;     // write to a register that exists
  logic      calc_busy;
  logic      hold;
  rsf_gaps_t gaps;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BAUD_RATE, REG_DATA_BITS, REG_PARITY_ENABLE, REG_STOP_CODE,
        REG_FRAME_GAP_OVERRIDE: cfg_hit = 1'b1;
        default:                cfg_hit = 1'b0;
      endcase
    end
  end

  // settings register file; writes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baud_rate          <= BAUD_W'(9600);
      cfg.data_bits          <= 4'd8;
      cfg.parity_enable      <= 1'b0;
      cfg.stop_code          <= 2'd1;
      cfg.frame_gap_override <= '0;
      recalc                 <= 1'b1;
    end else begin
      recalc <= cfg_hit;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BAUD_RATE:          cfg.baud_rate          <= cfg_data[BAUD_W-1:0];
          REG_DATA_BITS:          cfg.data_bits          <= cfg_data[3:0];
          REG_PARITY_ENABLE:      cfg.parity_enable      <= cfg_data[0];
          REG_STOP_CODE:          cfg.stop_code          <= cfg_data[1:0];
          REG_FRAME_GAP_OVERRIDE: cfg.frame_gap_override <= cfg_data[GAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // no word moves while a write lands or the gaps are being refreshed
  assign hold = cfg_we || recalc || calc_busy;

  rsf_gap_calc u_gap_calc (
    .clk   (clk),
    .rst   (rst),
    .start (recalc),
    .cfg   (cfg),
    .busy  (calc_busy),
    .gaps  (gaps)
  );

  rsf_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_core (
    .clk       (clk),
    .rst       (rst),
    .hold      (hold),
    .clr       (cfg_hit),
    .gaps      (gaps),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/sv/rtu_silence_framer_tb.sv @@
// rtu_silence_framer_tb: self-checking testbench for the rtu silence framer
// drives byte and tick words, predicts every result word and checks it in order
// depends on rsf_pkg and rtu_silence_framer

module rtu_silence_framer_tb;
  import rsf_pkg::*;

  // register count of the line settings; indexes from here up are unused
  localparam int unsigned NUM_REGS       = 5;
  // longest silence sent in one go, keeps slow line settings affordable
  localparam int unsigned SILENCE_CAP    = 2000;
  // cycles with nothing accepted before the run is called hung
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned PHASE_BYTES    = 150;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  rsf_in_t                in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  rsf_out_t               out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // line settings as the predictor sees them
  logic [BAUD_W-1:0] line_baud;
  logic [3:0]        line_dbits;
  logic              line_parity;
  logic [1:0]        line_stop;
  logic [GAP_W-1:0]  line_override;

  // framing state of the predictor
  logic [8:0]        frame_len;
  logic [GAP_W-1:0]  quiet_us;
  logic [GAP_W-1:0]  frame_gap_us;
  logic [GAP_W-1:0]  char_gap_us;

  rsf_out_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_left     = 0;
  bit          idle_on        = 1'b1;

  rtu_silence_framer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // gaps in microseconds: ceil(k * bits * 1e6 / (2 * baud)), k = 7 frame, 3 char
  function automatic void recompute_gaps();
    longint unsigned nbits;
    longint unsigned den;
    nbits = 1 + line_dbits + line_parity +
            ((line_stop == STOP_TWO || line_stop == STOP_ONE_HALF) ? 2 : 1);
    if (line_baud == 0 || line_baud > BAUD_FIXED_ABOVE) begin
      // fast lines and baud 0 use the fixed gaps
      frame_gap_us = FIXED_FRAME_GAP;
      char_gap_us  = FIXED_CHAR_GAP;
    end else begin
      den          = 2 * longint'(line_baud);
      frame_gap_us = (FRAME_FACTOR * nbits + den - 1) / den;
      char_gap_us  = (CHAR_FACTOR * nbits + den - 1) / den;
    end
    if (line_override != 0)
      frame_gap_us = line_override;
  endfunction

  function automatic void reset_framer_state();
    line_baud     = 9600;
    line_dbits    = 8;
    line_parity   = 1'b0;
    line_stop     = 2'd1;
    line_override = '0;
    frame_len     = '0;
    quiet_us      = '0;
    recompute_gaps();
  endfunction

  // a write to a known register recalculates the gaps and drops the open frame
  // silently; unused indexes leave everything alone
  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BAUD_RATE:          line_baud     = data[BAUD_W-1:0];
      REG_DATA_BITS:          line_dbits    = data[3:0];
      REG_PARITY_ENABLE:      line_parity   = data[0];
      REG_STOP_CODE:          line_stop     = data[1:0];
      REG_FRAME_GAP_OVERRIDE: line_override = data[GAP_W-1:0];
      default:                return;
    endcase
    recompute_gaps();
    frame_len = '0;
    quiet_us  = '0;
  endfunction

  function automatic rsf_out_t frame_step(rsf_in_t w);
    rsf_out_t r;
    r = '0;
    if (w.mode) begin
      // tick: silence grows (saturating), the open frame closes at the frame gap
      if (quiet_us != '1)
        quiet_us = quiet_us + 1'b1;
      if (frame_len != 0 && quiet_us >= frame_gap_us) begin
        r.frame_done    = 1'b1;
        r.closed_length = frame_len;
        frame_len       = '0;
      end
    end else begin
      if (frame_len != 0) begin
        if (quiet_us >= frame_gap_us) begin
          r.frame_done    = 1'b1;
          r.closed_length = frame_len;
          frame_len       = '0;
        end else if (quiet_us > char_gap_us) begin
          r.gap_dropped   = 1'b1;
          r.closed_length = frame_len;
          frame_len       = '0;
        end
      end
      // the byte that would push the frame past its limit is not taken
      if (frame_len == MAX_FRAME_BYTES) begin
        r.overflow_dropped = 1'b1;
        r.closed_length    = frame_len + 1'b1;
        frame_len          = '0;
      end else begin
        r.byte_valid = 1'b1;
        r.byte_out   = w.rx_byte;
        r.byte_index = frame_len[7:0];
        frame_len    = frame_len + 1'b1;
      end
      quiet_us = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : rx_stall
    bit rdy;
    if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 5);
    rdy = (stall_left == 0);
    if (stall_left != 0)
      stall_left--;
    out_ready <= rdy;
  end

  always @(posedge clk) begin : result_check
    rsf_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: done=%0d gap=%0d ovf=%0d len=%0d",
                   out_data.frame_done, out_data.gap_dropped,
                   out_data.overflow_dropped, out_data.closed_length);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"result word mismatch: expected done=%0d gap=%0d ovf=%0d len=%0d",
                      " valid=%0d byte=%02h idx=%0d, got done=%0d gap=%0d ovf=%0d",
                      " len=%0d valid=%0d byte=%02h idx=%0d"},
                     want.frame_done, want.gap_dropped, want.overflow_dropped,
                     want.closed_length, want.byte_valid, want.byte_out,
                     want.byte_index, out_data.frame_done, out_data.gap_dropped,
                     out_data.overflow_dropped, out_data.closed_length,
                     out_data.byte_valid, out_data.byte_out, out_data.byte_index);
        end
      end
    end
  end

  // hang detector: any accepted word on either side, or a register write, rearms it
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("** rtu_silence_framer: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input word; returns at the edge that accepted it with valid still high,
  // so the next word can follow back to back
  task automatic send_word(input rsf_in_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(frame_step(w));
  endtask

  task automatic send_rx_byte(input logic [7:0] b);
    rsf_in_t w;
    w.mode    = 1'b0;
    w.rx_byte = b;
    send_word(w);
  endtask

  // n microseconds of silence; the byte lane carries junk, which must be ignored
  task automatic send_ticks(input int unsigned n);
    rsf_in_t w;
    for (int unsigned i = 0; i < n; i++) begin
      w.mode    = 1'b1;
      w.rx_byte = $urandom;
      send_word(w);
    end
  endtask

  // drop valid, wait for every outstanding result word, then a short pause
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // caller has settled the block first
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_reg(idx, data);
    // wait out the gap recalculation
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // field value with random junk above the register width, which must be masked
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] field,
                                                      int unsigned w);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    if (w >= CFG_DATA_W)
      return field;
    return (junk << w) | field;
  endfunction

  task automatic apply_setting(input rsf_cfg_t s);
    settle();
    write_reg(REG_BAUD_RATE,          with_junk(s.baud_rate, BAUD_W));
    write_reg(REG_DATA_BITS,          with_junk(s.data_bits, 4));
    write_reg(REG_PARITY_ENABLE,      with_junk(s.parity_enable, 1));
    write_reg(REG_STOP_CODE,          with_junk(s.stop_code, 2));
    write_reg(REG_FRAME_GAP_OVERRIDE, s.frame_gap_override);
  endtask

  function automatic rsf_cfg_t random_setting();
    rsf_cfg_t s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      s.baud_rate = BAUD_FIXED_ABOVE;
    else if (pick < 35) s.baud_rate = '0;
    else if (pick < 65) s.baud_rate = $urandom_range(BAUD_FIXED_ABOVE + 1, 2**BAUD_W - 1);
    else                s.baud_rate = $urandom_range(4800, BAUD_FIXED_ABOVE);
    s.data_bits     = $urandom;
    s.parity_enable = $urandom;
    s.stop_code     = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 4)       s.frame_gap_override = '0;
    else if (pick < 8)  s.frame_gap_override = $urandom_range(1, 40);
    else if (pick < 9)  s.frame_gap_override = $urandom_range(150, 900);
    else                s.frame_gap_override = $urandom;
    return s;
  endfunction

  // silence that ends a frame: mostly short, often right on a gap boundary
  function automatic int unsigned pick_silence();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = $urandom_range(0, 3);
      4:          n = frame_gap_us - 1;
      5, 6:       n = frame_gap_us;
      7:          n = frame_gap_us + 1;
      8:          n = char_gap_us + 1;
      default:    n = $urandom_range(0, frame_gap_us + 2);
    endcase
    if (n > SILENCE_CAP)
      n = $urandom_range(0, 3);
    return n;
  endfunction

  // silence between bytes of a frame, now and then exactly the char gap
  function automatic int unsigned inner_silence();
    if ($urandom_range(0, 9) == 0 && char_gap_us <= SILENCE_CAP)
      return char_gap_us;
    return $urandom_range(0, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings give gaps far longer than these few words
  task automatic test_reset_settings();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_ticks(2);
    send_rx_byte(8'hA5);
    settle();
  endtask

  // a short override lets a tick run close the frame; ticks with nothing open
  // only count silence
  task automatic test_tick_closes_frame();
    write_reg(REG_FRAME_GAP_OVERRIDE, 26'd3);
    send_rx_byte(8'h5A);
    send_rx_byte(8'hC3);
    send_ticks(3);
    send_ticks(2);
    send_rx_byte(8'h01);
    send_ticks(3);
    settle();
  endtask

  // unused indexes change nothing; a known register drops the open frame silently
  task automatic test_register_write_clears();
    send_rx_byte(8'h80);
    send_rx_byte(8'h7F);
    settle();
    for (int unsigned i = NUM_REGS; i < 2**CFG_INDEX_W; i++)
      write_reg(i, $urandom);
    send_rx_byte(8'h33);
    settle();
    write_reg(REG_PARITY_ENABLE, with_junk(1'b0, 1));
    send_rx_byte(8'hCC);
    settle();
  endtask

  // silence of exactly the char gap keeps the fragment, one more drops it and
  // the late byte opens the next frame at index 0
  task automatic test_char_gap_drop();
    rsf_cfg_t s;
    s = '{baud_rate: BAUD_FIXED_ABOVE, data_bits: 4'd0, parity_enable: 1'b0,
          stop_code: 2'd0, frame_gap_override: '0};
    apply_setting(s);
    repeat (3) send_rx_byte($urandom);
    send_ticks(char_gap_us);
    send_rx_byte($urandom);
    send_ticks(char_gap_us + 1);
    send_rx_byte($urandom);
    send_ticks(frame_gap_us);
    settle();
  endtask

  // a full frame takes index 255; the next byte is refused and the frame dropped
  task automatic test_overflow();
    for (int unsigned i = 0; i <= MAX_FRAME_BYTES; i++)
      send_rx_byte($urandom);
    send_rx_byte($urandom);
    send_ticks(2);
    settle();
  endtask

  // mostly well-formed frames with random content, the rest noise and broken ones
  task automatic run_mixed_phase(input rsf_cfg_t s, input int unsigned byte_budget);
    int unsigned bytes_sent;
    int unsigned pick;
    int unsigned len;
    rsf_in_t     w;
    apply_setting(s);
    bytes_sent = 0;
    while (bytes_sent < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int unsigned k = 0; k < len; k++) begin
          send_rx_byte($urandom);
          if (k + 1 < len)
            send_ticks(inner_silence());
        end
        bytes_sent += len;
        send_ticks(pick_silence());
      end else if (pick < 75) begin
        send_ticks(pick_silence());
      end else if (pick < 88) begin
        len = $urandom_range(1, 10);
        for (int unsigned k = 0; k < len; k++) begin
          w = $urandom;
          send_word(w);
          if (!w.mode)
            bytes_sent++;
        end
      end else if (pick < 97) begin
        // fragment broken by a char gap violation, then a fresh byte
        len = $urandom_range(1, 3);
        repeat (len) send_rx_byte($urandom);
        if (char_gap_us < SILENCE_CAP)
          send_ticks(char_gap_us + 1);
        else
          send_ticks($urandom_range(0, 3));
        send_rx_byte($urandom);
        bytes_sent += len + 1;
      end else begin
        // run up to or past the frame size limit
        len = $urandom_range(MAX_FRAME_BYTES - 6, MAX_FRAME_BYTES + 2);
        repeat (len) send_rx_byte($urandom);
        bytes_sent += len;
      end
    end
    settle();
  endtask

  task automatic test_random_settings();
    rsf_cfg_t extremes[6];
    // minimum bits at the threshold rate, fixed gaps just above it, maximum bits
    // with baud 0, top of the baud field, the slowest line, largest override
    extremes[0] = '{BAUD_FIXED_ABOVE, 4'd0, 1'b0, 2'd0, 26'd0};
    extremes[1] = '{BAUD_FIXED_ABOVE + 1, 4'd8, 1'b0, 2'd1, 26'd0};
    extremes[2] = '{22'd0, 4'd15, 1'b1, STOP_ONE_HALF, 26'd4};
    extremes[3] = '{{BAUD_W{1'b1}}, 4'd5, 1'b1, STOP_TWO, 26'd1};
    extremes[4] = '{22'd1, 4'd15, 1'b1, STOP_TWO, 26'd0};
    extremes[5] = '{BAUD_FIXED_ABOVE, 4'd5, 1'b0, 2'd1, {GAP_W{1'b1}}};
    foreach (extremes[i]) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_mixed_phase(extremes[i], PHASE_BYTES);
    end
    repeat (6) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_mixed_phase(random_setting(), PHASE_BYTES);
    end
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    run_mixed_phase(random_setting(), PHASE_BYTES);
  endtask

  initial begin
    reset_framer_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_tick_closes_frame();
    test_register_write_clears();
    test_char_gap_drop();
    test_overflow();
    test_random_settings();
    test_full_rate();

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** rtu_silence_framer: PASSED **");
    end else begin
      $display("** rtu_silence_framer: FAILED **");
    end
    $finish;
  end

endmodule
